FILE: rtl/core/assert_macros.svh
// assertion macros for the renderer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define SGCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define SGCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sgcr_pkg.sv
// shared constants, font rom and column stretch helpers for the glyph renderer
`default_nettype none

package sgcr_pkg;

  // column buffer geometry: one entry per cell column, 7 rows times 3 at most
  localparam int unsigned COL_WIDTH = 24;
  localparam int unsigned COL_DEPTH = 8;
  localparam int unsigned COL_AW    = 3;

  localparam logic [COL_AW-1:0] LAST_COL  = 3'd5;  // blank spacer column
  localparam logic [COL_AW-1:0] LAST_GLYPH_COL = 3'd4;

  localparam int unsigned GLYPHS = 24;

  // character codes with a glyph
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  // font rom, column c of a glyph sits in bits [8c+7:8c]
  localparam logic [39:0] FONT_ROM [GLYPHS] = '{
    40'h00_00_00_00_00,  // blank
    40'h08_08_08_08_08,  // dash
    40'h02_04_08_10_20,  // slash
    40'h00_00_36_36_00,  // colon
    40'h3E_45_49_51_3E,  // 0
    40'h00_40_7F_42_00,  // 1
    40'h46_49_51_61_42,  // 2
    40'h31_4B_45_41_21,  // 3
    40'h10_7F_12_14_18,  // 4
    40'h39_45_45_45_27,  // 5
    40'h30_49_49_4A_3C,  // 6
    40'h03_05_09_71_01,  // 7
    40'h36_49_49_49_36,  // 8
    40'h1E_29_49_49_06,  // 9
    40'h7E_11_11_11_7E,  // A
    40'h36_49_49_49_7F,  // B
    40'h22_41_41_41_3E,  // C
    40'h7A_49_49_41_3E,  // G
    40'h00_41_7F_41_00,  // I
    40'h7F_02_0C_02_7F,  // M
    40'h7F_10_08_04_7F,  // N
    40'h46_29_19_09_7F,  // R
    40'h31_49_49_49_46,  // S
    40'h01_01_7F_01_01   // T
  };

  function automatic logic [4:0] glyph_index(logic [7:0] code);
    logic [4:0] idx;
    idx = 5'd0;
    case (code) inside
      [CH_ZERO:CH_NINE]: idx = 5'({1'b0, code[3:0]}) + 5'd4;
      CH_DASH:           idx = 5'd1;
      CH_SLASH:          idx = 5'd2;
      CH_COLON:          idx = 5'd3;
      CH_A:              idx = 5'd14;
      CH_B:              idx = 5'd15;
      CH_C:              idx = 5'd16;
      CH_G:              idx = 5'd17;
      CH_I:              idx = 5'd18;
      CH_M:              idx = 5'd19;
      CH_N:              idx = 5'd20;
      CH_R:              idx = 5'd21;
      CH_S:              idx = 5'd22;
      CH_T:              idx = 5'd23;
      default:           idx = 5'd0;
    endcase
    return idx;
  endfunction

  // one font column, the spacer column reads blank
  function automatic logic [6:0] font_column(logic [7:0] code, logic [COL_AW-1:0] col);
    logic [39:0] glyph;
    logic [7:0]  bits;
    glyph = FONT_ROM[glyph_index(code)];
    bits  = 8'h00;
    if (col <= LAST_GLYPH_COL) begin
      bits = glyph[{col, 3'b000} +: 8];
    end
    return bits[6:0];
  endfunction

  // stretch a 7-row column vertically by the scale
  function automatic logic [COL_WIDTH-1:0] stretch_column(logic [6:0] bits,
                                                          logic [1:0] scale);
    logic [COL_WIDTH-1:0] t1;
    logic [COL_WIDTH-1:0] t2;
    logic [COL_WIDTH-1:0] t3;
    logic [COL_WIDTH-1:0] res;
    t1 = {17'd0, bits};
    t2 = '0;
    t3 = '0;
    for (int r = 0; r < 7; r++) begin
      t2[2*r +: 2] = {2{bits[r]}};
      t3[3*r +: 3] = {3{bits[r]}};
    end
    case (scale)
      2'd2:    res = t2;
      2'd3:    res = t3;
      default: res = t1;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sgcr_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module sgcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/scaled_glyph_column_renderer.sv
// top level of the scaled glyph column renderer
// usage:
//   one character request comes in on the s_axis group; tuser marks the first
//   character of a string, which also loads start column, start page and scale
//   (scale 0 counts as 1). results leave on the m_axis group as positioned
//   column bytes, tlast set on the final byte of each character.
// sequence:
//   a request is taken only when the renderer is idle. a drawn character goes
//   through the accept, the fit check and 6 column buffer writes, then per
//   cell column one buffer read and s*p bytes, where s is the scale and p the
//   pages drawn (at most s). a character of a halted string, or one that does
//   not fit, gives nothing.
// reset:
//   the string is halted, so nothing is drawn until a first-of-string request.
// stall:
//   bytes go through a one-deep output register; while the receiver holds
//   tready low the renderer waits on it, and the next request is taken while
//   the last byte of a character still sits there.
`default_nettype none
`include "assert_macros.svh"

module scaled_glyph_column_renderer
  import sgcr_pkg::*;
#(
  parameter int unsigned DISPLAY_COLUMNS = 128,
  parameter int unsigned DISPLAY_PAGES   = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // char_code [7:0], start_column [14:8], start_page [17:15], scale [19:18]
  input  wire logic [23:0] s_axis_tdata_i,
  // first_of_string [0]
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // column [6:0], page [9:7], pixels [17:10]
  output logic      [23:0] m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  // limits widened to the compare widths below
  localparam logic [8:0] NumCols  = 9'(DISPLAY_COLUMNS);
  localparam logic [4:0] NumPages = 5'(DISPLAY_PAGES);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_BUILD = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // string state
  logic [7:0] cursor_q, cursor_d;
  logic [2:0] page_q, page_d;
  logic [1:0] scale_q, scale_d;
  logic       halted_q, halted_d;

  // per character working registers
  logic [7:0]        code_q, code_d;
  logic [COL_AW-1:0] col_q, col_d;      // cell column, also buffer address
  logic [1:0]        sx_q, sx_d;        // horizontal copy
  logic [1:0]        po_q, po_d;        // page offset
  logic [7:0]        col_pos_q, col_pos_d;  // display column being drawn

  // output register
  logic        m_valid_q;
  logic [6:0]  out_col_q;
  logic [2:0]  out_page_q;
  logic [7:0]  out_pix_q;
  logic        out_last_q;
  logic        out_load;
  logic        out_last_d;
  logic        out_free;

  // column buffer port
  logic                 ram_we;
  logic                 ram_re;
  logic [COL_WIDTH-1:0] ram_wdata;
  logic [COL_WIDTH-1:0] ram_rdata;

  logic       in_accept;
  logic [4:0] six_s;
  logic [8:0] fit_sum;
  logic [4:0] page_next;
  logic       page_end;
  logic [1:0] in_scale;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign in_scale = (s_axis_tdata_i[19:18] == 2'd0) ? 2'd1 : s_axis_tdata_i[19:18];

  // 6*scale, then the fit test on the cell width
  assign six_s   = {1'b0, scale_q, 2'b00} + {2'b00, scale_q, 1'b0};
  assign fit_sum = {1'b0, cursor_q} + {4'd0, six_s};

  // the page after this one ends the column if past the stretch or the display
  assign page_next = {2'b00, page_q} + {3'b000, po_q} + 5'd1;
  assign page_end  = (po_q == scale_q - 2'd1) || (page_next >= NumPages);

  // buffer writes happen only while building and reads only afterwards,
  // so a read never meets a write to the same entry
  assign ram_wdata = stretch_column(font_column(code_q, col_q), scale_q);

  always_comb begin
    state_d    = state_q;
    cursor_d   = cursor_q;
    page_d     = page_q;
    scale_d    = scale_q;
    halted_d   = halted_q;
    code_d     = code_q;
    col_d      = col_q;
    sx_d       = sx_q;
    po_d       = po_q;
    col_pos_d  = col_pos_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    out_last_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          code_d = s_axis_tdata_i[7:0];
          if (s_axis_tuser_i) begin
            cursor_d = {1'b0, s_axis_tdata_i[14:8]};
            page_d   = s_axis_tdata_i[17:15];
            scale_d  = in_scale;
            halted_d = ({2'b00, s_axis_tdata_i[17:15]} >= NumPages);
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (halted_q) begin
          state_d = ST_IDLE;
        end else if (fit_sum > NumCols) begin
          // character runs off the right edge: the string stops here
          halted_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          cursor_d  = fit_sum[7:0];
          col_pos_d = cursor_q;
          col_d     = '0;
          state_d   = ST_BUILD;
        end
      end
      ST_BUILD: begin
        ram_we = 1'b1;
        if (col_q == LAST_COL) begin
          col_d   = '0;
          state_d = ST_FETCH;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_FETCH: begin
        ram_re  = 1'b1;
        sx_d    = 2'd0;
        po_d    = 2'd0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!page_end) begin
            po_d = po_q + 2'd1;
          end else begin
            po_d      = 2'd0;
            col_pos_d = col_pos_q + 8'd1;
            if (sx_q != scale_q - 2'd1) begin
              sx_d = sx_q + 2'd1;
            end else if (col_q == LAST_COL) begin
              out_last_d = 1'b1;
              state_d    = ST_IDLE;
            end else begin
              col_d   = col_q + 1'b1;
              state_d = ST_FETCH;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cursor_q  <= 8'd0;
      page_q    <= 3'd0;
      scale_q   <= 2'd1;
      halted_q  <= 1'b1;
      col_q     <= '0;
      sx_q      <= 2'd0;
      po_q      <= 2'd0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      page_q   <= page_d;
      scale_q  <= scale_d;
      halted_q <= halted_d;
      col_q    <= col_d;
      sx_q     <= sx_d;
      po_q     <= po_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    col_pos_q <= col_pos_d;
    if (out_load) begin
      out_col_q  <= col_pos_q[6:0];
      out_page_q <= page_q + {1'b0, po_q};
      out_pix_q  <= 8'(ram_rdata >> {po_q, 3'b000});
      out_last_q <= out_last_d;
    end
  end

  // stretched column buffer, one entry per cell column
  sgcr_ram #(
    .WIDTH (COL_WIDTH),
    .DEPTH (COL_DEPTH)
  ) u_col_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_pix_q, out_page_q, out_col_q};
  assign m_axis_tlast_o  = out_last_q;

  // latched scale never takes the zero code
  `SGCR_ASSERT(a_scale_nonzero, clk_i, rst_ni, scale_q != 2'd0, "string scale is zero")

  // cell column counter stays inside the buffer's used entries
  `SGCR_ASSERT(a_col_range, clk_i, rst_ni, col_q <= LAST_COL, "cell column out of range")

  // the last byte of a character only comes from the final copy of the spacer
  `SGCR_ASSERT(a_last_on_final_copy, clk_i, rst_ni,
    (out_load && out_last_d) |-> ((col_q == LAST_COL) && (sx_q == scale_q - 2'd1)),
    "last byte flagged before the final column copy")

  // a halted string goes straight back to idle without touching the buffer
  `SGCR_ASSERT(a_halted_returns_idle, clk_i, rst_ni,
    ((state_q == ST_CHECK) && halted_q) |=> (state_q == ST_IDLE),
    "halted string did not return to idle")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the scaled glyph column renderer, stream in and stream out
module testbench;
  import sgcr_pkg::*;

  localparam int unsigned DISPLAY_COLS  = 128;
  localparam int unsigned DISPLAY_PAGE_COUNT = 8;
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 3000; // cycles with no handshake at all
  localparam int unsigned STEADY_GOAL   = 100;   // requests queued by the end of the steady run
  localparam int unsigned ITEM_GOAL     = 280;
  localparam int unsigned IDLE_PERCENT  = 14;

  // one character request as it travels on the slave side
  typedef struct packed {
    logic [7:0] code;
    logic       first;
    logic [6:0] start_column;
    logic [2:0] start_page;
    logic [1:0] scale;
  } glyph_req_t;

  // one positioned column byte as it leaves on the master side
  typedef struct packed {
    logic [6:0] column;
    logic [2:0] page;
    logic [7:0] pixels;
    logic       last;
  } col_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // char_code [7:0], start_column [14:8], start_page [17:15], scale [19:18]
  logic [23:0] s_axis_tdata_i = '0;
  // first_of_string [0]
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // column [6:0], page [9:7], pixels [17:10]
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  scaled_glyph_column_renderer #(
    .DISPLAY_COLUMNS(DISPLAY_COLS),
    .DISPLAY_PAGES  (DISPLAY_PAGE_COUNT)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  glyph_req_t  pending_reqs[$];
  col_byte_t   expected_bytes[$];
  glyph_req_t  offered_req;
  col_byte_t   head_byte;
  int unsigned queued_items = 0;
  int unsigned mismatches = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;  // no random idling on either side

  // renderer state as the predictor sees it
  logic [7:0] pen_column = 8'd0;
  logic [2:0] line_page = 3'd0;
  logic [1:0] line_scale = 2'd1;
  bit         line_halted = 1'b1;

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // 5x7 glyphs, leftmost column in the top byte, bit 0 is the top row
  function automatic logic [39:0] glyph_columns(input logic [7:0] code);
    case (code)
      CH_DASH:          return 40'h08_08_08_08_08;
      CH_SLASH:         return 40'h20_10_08_04_02;
      CH_COLON:         return 40'h00_36_36_00_00;
      CH_ZERO:          return 40'h3E_51_49_45_3E;
      CH_ZERO + 8'd1:   return 40'h00_42_7F_40_00;
      CH_ZERO + 8'd2:   return 40'h42_61_51_49_46;
      CH_ZERO + 8'd3:   return 40'h21_41_45_4B_31;
      CH_ZERO + 8'd4:   return 40'h18_14_12_7F_10;
      CH_ZERO + 8'd5:   return 40'h27_45_45_45_39;
      CH_ZERO + 8'd6:   return 40'h3C_4A_49_49_30;
      CH_ZERO + 8'd7:   return 40'h01_71_09_05_03;
      CH_ZERO + 8'd8:   return 40'h36_49_49_49_36;
      CH_NINE:          return 40'h06_49_49_29_1E;
      CH_A:             return 40'h7E_11_11_11_7E;
      CH_B:             return 40'h7F_49_49_49_36;
      CH_C:             return 40'h3E_41_41_41_22;
      CH_G:             return 40'h3E_41_49_49_7A;
      CH_I:             return 40'h00_41_7F_41_00;
      CH_M:             return 40'h7F_02_0C_02_7F;
      CH_N:             return 40'h7F_04_08_10_7F;
      CH_R:             return 40'h7F_09_19_29_46;
      CH_S:             return 40'h46_49_49_49_31;
      CH_T:             return 40'h01_01_7F_01_01;
      default:          return 40'h0;
    endcase
  endfunction

  // works out the column bytes one accepted character request gives
  task automatic render_char(input glyph_req_t req);
    logic [39:0] glyph;
    logic [7:0]  font_col;
    logic [23:0] tall;
    col_byte_t   b;
    int          s;
    int          npages;
    int          shown_pages;
    int          total;
    int          idx;
    if (req.first) begin
      pen_column  = {1'b0, req.start_column};
      line_page   = req.start_page;
      line_scale  = (req.scale == 2'd0) ? 2'd1 : req.scale;
      line_halted = (int'(req.start_page) >= DISPLAY_PAGE_COUNT);
    end
    if (line_halted) return;
    s = int'(line_scale);
    // a character that runs past the right edge ends the string
    if (int'(pen_column) + 6 * s > DISPLAY_COLS) begin
      line_halted = 1'b1;
      return;
    end
    npages = (7 * s + 7) / 8;
    shown_pages = npages;
    // pages below the bottom of the display are dropped
    if (int'(line_page) + npages > DISPLAY_PAGE_COUNT)
      shown_pages = DISPLAY_PAGE_COUNT - int'(line_page);
    total = 6 * s * shown_pages;
    glyph = glyph_columns(req.code);
    idx = 0;
    for (int c = 0; c < 6; c++) begin
      font_col = (c < 5) ? glyph[39 - 8 * c -: 8] : 8'h00;
      tall = '0;
      for (int r = 0; r < 7; r++) begin
        if (font_col[r]) begin
          for (int y = 0; y < s; y++) tall[r * s + y] = 1'b1;
        end
      end
      for (int sx = 0; sx < s; sx++) begin
        for (int po = 0; po < shown_pages; po++) begin
          b.column = 7'(int'(pen_column) + c * s + sx);
          b.page   = 3'(int'(line_page) + po);
          b.pixels = tall[8 * po +: 8];
          b.last   = (idx == total - 1);
          expected_bytes.push_back(b);
          idx++;
        end
      end
    end
    pen_column = 8'(int'(pen_column) + 6 * s);
  endtask

  // sender: offers the queued requests, idling now and then
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) render_char(offered_req);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_reqs.size() != 0 &&
            (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          offered_req = pending_reqs.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {4'd0, offered_req.scale, offered_req.start_page,
                              offered_req.start_column, offered_req.code};
          s_axis_tuser_i  <= offered_req.first;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each column byte and drives tready, with a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte with nothing expected, tdata %h tlast %b",
                                    m_axis_tdata_o, m_axis_tlast_o));
        end else begin
          head_byte = expected_bytes.pop_front();
          if (m_axis_tdata_o[6:0] != head_byte.column ||
              m_axis_tdata_o[9:7] != head_byte.page ||
              m_axis_tdata_o[17:10] != head_byte.pixels ||
              m_axis_tlast_o != head_byte.last)
            report_mismatch($sformatf(
              "col %0d page %0d pix %h last %b, want col %0d page %0d pix %h last %b",
              m_axis_tdata_o[6:0], m_axis_tdata_o[9:7], m_axis_tdata_o[17:10],
              m_axis_tlast_o, head_byte.column, head_byte.page, head_byte.pixels,
              head_byte.last));
        end
      end
      if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left <= HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // fields that a continuing character ignores are filled with junk
  task automatic queue_glyph(input logic [7:0] code, input logic first,
                             input logic [6:0] col, input logic [2:0] pg,
                             input logic [1:0] scl);
    glyph_req_t r;
    r.code  = code;
    r.first = first;
    r.start_column = first ? col : 7'($urandom_range(127));
    r.start_page   = first ? pg : 3'($urandom_range(7));
    r.scale        = first ? scl : 2'($urandom_range(3));
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  function automatic logic [7:0] pick_code();
    int unsigned k;
    if ($urandom_range(99) < 25) return 8'($urandom_range(255));
    k = $urandom_range(23);
    if (k < 10) return CH_ZERO + 8'(k);
    case (k)
      10: return CH_DASH;
      11: return CH_SLASH;
      12: return CH_COLON;
      13: return CH_A;
      14: return CH_B;
      15: return CH_C;
      16: return CH_G;
      17: return CH_I;
      18: return CH_M;
      19: return CH_N;
      20: return CH_R;
      21: return CH_S;
      22: return CH_T;
      default: return 8'h20;  // space, no glyph
    endcase
  endfunction

  // mostly a whole string from a start that fits, sometimes loose noise requests
  task automatic queue_text_line();
    int unsigned eff;
    int unsigned n;
    logic [1:0]  scl;
    logic [6:0]  col;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(3, 1);
      for (int k = 0; k < n; k++)
        queue_glyph(8'($urandom_range(255)), 1'($urandom_range(1)),
                    7'($urandom_range(127)), 3'($urandom_range(7)), 2'($urandom_range(3)));
    end else begin
      scl = 2'($urandom_range(3));
      eff = (scl == 2'd0) ? 1 : scl;
      col = ($urandom_range(9) < 8) ? 7'($urandom_range(DISPLAY_COLS - 6 * eff))
                                    : 7'($urandom_range(127));
      n = $urandom_range(8, 1);
      queue_glyph(pick_code(), 1'b1, col, 3'($urandom_range(7)), scl);
      for (int k = 1; k < n; k++) queue_glyph(pick_code(), 1'b0, '0, '0, '0);
    end
  endtask

  // sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid_i || expected_bytes.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: nothing drawn before the first string
    queue_glyph(CH_A, 1'b0, '0, '0, '0);
    queue_glyph(CH_ZERO, 1'b1, 7'd0, 3'd0, 2'd1);
    queue_glyph(CH_DASH, 1'b0, '0, '0, '0);
    queue_glyph(CH_SLASH, 1'b0, '0, '0, '0);
    queue_glyph(CH_COLON, 1'b0, '0, '0, '0);
    queue_glyph(8'h00, 1'b0, '0, '0, '0);        // code zero, blank
    queue_glyph(8'hFF, 1'b0, '0, '0, '0);        // no glyph
    // bottom page: lower pages of a tall glyph fall off the display
    queue_glyph(CH_B, 1'b1, 7'd0, 3'd7, 2'd3);
    queue_glyph(CH_M, 1'b0, '0, '0, '0);
    // exact fit at the right edge, then run-off halts the string
    queue_glyph(CH_S, 1'b1, 7'd110, 3'd2, 2'd3);
    queue_glyph(CH_T, 1'b0, '0, '0, '0);
    queue_glyph(CH_ZERO + 8'd8, 1'b0, '0, '0, '0);
    // scale zero counts as one; last column cannot fit a cell
    queue_glyph(CH_G, 1'b1, 7'd127, 3'd5, 2'd0);
    queue_glyph(CH_R, 1'b1, 7'd122, 3'd4, 2'd0);
    queue_glyph(CH_N, 1'b0, '0, '0, '0);
    queue_glyph(CH_ZERO + 8'd7, 1'b1, 7'd64, 3'd6, 2'd2);
    queue_glyph(CH_I, 1'b1, 7'd9, 3'd7, 2'd2);
    queue_glyph(CH_C, 1'b0, '0, '0, '0);
    queue_glyph(CH_NINE, 1'b1, 7'd0, 3'd3, 2'd3);
    queue_glyph(CH_ZERO + 8'd4, 1'b0, '0, '0, '0);
    queue_glyph(8'h80, 1'b1, 7'd85, 3'd1, 2'd2);
    queue_glyph(CH_ZERO + 8'd5, 1'b0, '0, '0, '0);
    wait_drained();

    // a stretch with no idling on either side
    steady = 1'b1;
    while (queued_items < STEADY_GOAL) begin
      if (pending_reqs.size() < 4) queue_text_line();
      @(negedge clk_i);
    end
    wait_drained();
    steady = 1'b0;

    // receiver holds off while a full string of large glyphs is offered
    for (int k = 0; k < 6; k++)
      queue_glyph(pick_code(), k == 0, 7'd5, 3'd2, 2'd3);
    hold_requests = hold_requests + 1;
    wait_drained();

    while (queued_items < ITEM_GOAL) begin
      if (pending_reqs.size() < 4) queue_text_line();
      @(negedge clk_i);
    end
    wait_drained();

    // let a character still in flight show up, if one should not be there
    repeat (80) @(posedge clk_i);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d column bytes never arrived", expected_bytes.size()));
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
